// File: design/gwg_pkg.sv
package gwg_pkg;

	// Field and datapath widths.
	localparam int POS_W  = 24;
	localparam int D_W    = 25;
	localparam int ABS_W  = 24;
	localparam int SQ_W   = 48;
	localparam int M_W    = 48;
	localparam int ITV_W  = 24;
	localparam int NORM_W = 32;
	localparam int OUT_W  = 32;
	localparam int TAB_W  = 31;

	// Pipeline shape: two lane stages, ten stages of weight evaluation, three gradient stages.
	localparam int WEIGHT_LAT = 10;
	localparam int PIPE_DEPTH = 15;

	// Output queue that decouples the pipeline from the result stall.
	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = 5;
	localparam int CNT_W      = 6;

	// Fixed-point constants, both Q.30.
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;

	// Register reset values.
	localparam logic [ITV_W-1:0]  ITV_RESET  = 24'd32768;
	localparam logic [NORM_W-1:0] NORM_RESET = 32'd1065256;

	// Register indexes on the configuration port.
	typedef enum logic [0:0] {
		REG_INV_TWO_VAR = 1'b0,
		REG_NORM_FACTOR = 1'b1
	} reg_idx_t;

endpackage

// File: design/gaussian_weight_and_gradient_3d_unit.sv
// Isotropic 3D Gaussian kernel with position gradient. Each transaction carries a sample
// position and a voxel centre (signed, POS_FRAC_BITS fraction bits) and returns the weight
// norm_factor * exp(-|d|^2 * inv_two_var) in unsigned Q8.24 together with the gradient
// -2 * inv_two_var * weight * d per axis in saturating signed Q8.24. Three lanes handle the
// axes; their squares merge into one exp unit (log2 range reduction, a registered read of an
// EXP_TABLE_DEPTH+1 entry table and linear interpolation), and the weight returns to the lanes
// for the gradient. One transaction is accepted per cycle while sample_stall is low; a result
// becomes valid once it has passed the 15-stage datapath, whose first stage loads at the
// accepting edge, and the output queue write. Results wait in a 32-entry output queue, and
// sample_stall rises only when 32 transactions are in flight or waiting, so a stalled output
// only halts intake once that queue is committed. Registers sit at byte 0 (inv_two_var) and
// byte 4 (norm_factor); the user must write them while idle, which the block does not enforce.
module gaussian_weight_and_gradient_3d_unit #(
	parameter int POS_FRAC_BITS   = 16,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic signed [gwg_pkg::POS_W-1:0]  pos_x,
	input  logic signed [gwg_pkg::POS_W-1:0]  pos_y,
	input  logic signed [gwg_pkg::POS_W-1:0]  pos_z,
	input  logic signed [gwg_pkg::POS_W-1:0]  centre_x,
	input  logic signed [gwg_pkg::POS_W-1:0]  centre_y,
	input  logic signed [gwg_pkg::POS_W-1:0]  centre_z,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [gwg_pkg::OUT_W-1:0]         weight,
	output logic signed [gwg_pkg::OUT_W-1:0]  grad_x,
	output logic signed [gwg_pkg::OUT_W-1:0]  grad_y,
	output logic signed [gwg_pkg::OUT_W-1:0]  grad_z
);

	typedef struct packed {
		logic [gwg_pkg::OUT_W-1:0] weight;
		logic [gwg_pkg::OUT_W-1:0] grad_x;
		logic [gwg_pkg::OUT_W-1:0] grad_y;
		logic [gwg_pkg::OUT_W-1:0] grad_z;
	} result_t;

	logic [gwg_pkg::ITV_W-1:0]   inv_two_var_q;
	logic [gwg_pkg::NORM_W-1:0]  norm_factor_q;
	gwg_pkg::reg_idx_t           reg_idx;
	logic                        cfg_write;
	logic                        accept_in;
	logic                        accept_out;
	logic [gwg_pkg::PIPE_DEPTH-1:0] vld_q;
	logic [gwg_pkg::CNT_W-1:0]   credit_q;
	logic [gwg_pkg::SQ_W-1:0]    sq_x;
	logic [gwg_pkg::SQ_W-1:0]    sq_y;
	logic [gwg_pkg::SQ_W-1:0]    sq_z;
	logic [gwg_pkg::OUT_W-1:0]   weight_s12;
	logic [gwg_pkg::OUT_W-1:0]   weight_s13;
	logic [gwg_pkg::OUT_W-1:0]   weight_s14;
	logic [gwg_pkg::OUT_W-1:0]   weight_s15;
	logic [gwg_pkg::OUT_W-1:0]   gx_s15;
	logic [gwg_pkg::OUT_W-1:0]   gy_s15;
	logic [gwg_pkg::OUT_W-1:0]   gz_s15;
	logic                        push;
	result_t                     fifo_q [gwg_pkg::FIFO_DEPTH];
	logic [gwg_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [gwg_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [gwg_pkg::CNT_W-1:0]   fcnt_q;
	result_t                     head;

	// Configuration port.
	assign pready    = 1'b1;
	assign reg_idx   = gwg_pkg::reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_two_var_q <= gwg_pkg::ITV_RESET;
			norm_factor_q <= gwg_pkg::NORM_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				gwg_pkg::REG_INV_TWO_VAR: inv_two_var_q <= pwdata[gwg_pkg::ITV_W-1:0];
				gwg_pkg::REG_NORM_FACTOR: norm_factor_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gwg_pkg::REG_INV_TWO_VAR: prdata = 32'(inv_two_var_q);
			gwg_pkg::REG_NORM_FACTOR: prdata = norm_factor_q;
			default:                  prdata = '0;
		endcase
	end

	// Intake is limited by credits: transactions in the pipeline plus those queued.
	assign sample_stall = (credit_q == gwg_pkg::CNT_W'(gwg_pkg::FIFO_DEPTH));
	assign accept_in    = sample_valid && !sample_stall;
	assign result_valid = (fcnt_q != '0);
	assign accept_out   = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			vld_q    <= '0;
		end else begin
			credit_q <= credit_q + gwg_pkg::CNT_W'(accept_in) - gwg_pkg::CNT_W'(accept_out);
			vld_q    <= {vld_q[gwg_pkg::PIPE_DEPTH-2:0], accept_in};
		end
	end

	// Per-axis lanes.
	gwg_lane #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_lane_x (
		.clk(clk), .pos(pos_x), .centre(centre_x), .inv_two_var(inv_two_var_q),
		.weight(weight_s12), .sq(sq_x), .grad(gx_s15)
	);

	gwg_lane #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_lane_y (
		.clk(clk), .pos(pos_y), .centre(centre_y), .inv_two_var(inv_two_var_q),
		.weight(weight_s12), .sq(sq_y), .grad(gy_s15)
	);

	gwg_lane #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_lane_z (
		.clk(clk), .pos(pos_z), .centre(centre_z), .inv_two_var(inv_two_var_q),
		.weight(weight_s12), .sq(sq_z), .grad(gz_s15)
	);

	// Shared exp unit that merges the lanes.
	gwg_weight #(
		.POS_FRAC_BITS(POS_FRAC_BITS),
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_weight (
		.clk(clk), .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z),
		.inv_two_var(inv_two_var_q), .norm_factor(norm_factor_q), .weight(weight_s12)
	);

	// Keep the weight aligned with the gradient stages.
	always_ff @(posedge clk) begin
		weight_s13 <= weight_s12;
		weight_s14 <= weight_s13;
		weight_s15 <= weight_s14;
	end

	// Output queue.
	assign push = vld_q[gwg_pkg::PIPE_DEPTH-1];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{weight: weight_s15, grad_x: gx_s15, grad_y: gy_s15,
				grad_z: gz_s15};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (accept_out) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fcnt_q <= fcnt_q + gwg_pkg::CNT_W'(push) - gwg_pkg::CNT_W'(accept_out);
		end
	end

	assign head   = fifo_q[rd_ptr_q];
	assign weight = head.weight;
	assign grad_x = head.grad_x;
	assign grad_y = head.grad_y;
	assign grad_z = head.grad_z;

`ifndef SYNTHESIS
	// Every credit is held by exactly one transaction, in flight or queued.
	a_credit_balance: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(vld_q) + int'(fcnt_q)) == int'(credit_q))
		else $error("credit count does not match transactions in flight and queued");

	// The credit count never exceeds the queue capacity.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= gwg_pkg::CNT_W'(gwg_pkg::FIFO_DEPTH))
		else $error("credit count exceeds output queue depth");

	// A zero weight forces zero gradients; a mismatch means the lanes and weight slipped.
	a_zero_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && weight == '0) |-> (grad_x == '0 && grad_y == '0 && grad_z == '0))
		else $error("nonzero gradient with zero weight");
`endif

endmodule

// File: design/gwg_lane.sv
module gwg_lane #(
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic signed [gwg_pkg::POS_W-1:0]   pos,
	input  logic signed [gwg_pkg::POS_W-1:0]   centre,
	input  logic        [gwg_pkg::ITV_W-1:0]   inv_two_var,
	input  logic        [gwg_pkg::OUT_W-1:0]   weight,
	output logic        [gwg_pkg::SQ_W-1:0]    sq,
	output logic        [gwg_pkg::OUT_W-1:0]   grad
);

	localparam int HALF_W = gwg_pkg::M_W / 2;
	localparam int PP_W   = HALF_W + gwg_pkg::OUT_W;
	localparam int P_W    = gwg_pkg::M_W + gwg_pkg::OUT_W;
	localparam int MAG_W  = P_W - (POS_FRAC_BITS + 15);

	logic signed [gwg_pkg::D_W-1:0]   d_s1;
	logic        [gwg_pkg::ABS_W-1:0] ad;
	logic        [gwg_pkg::SQ_W-1:0]  sq_s2;
	logic        [gwg_pkg::M_W-1:0]   m_s2;
	logic                             pos_s2;
	logic        [gwg_pkg::M_W-1:0]   m_line_q [gwg_pkg::WEIGHT_LAT];
	logic                             pos_line_q [gwg_pkg::WEIGHT_LAT];
	logic        [gwg_pkg::M_W-1:0]   m_tap;
	logic        [PP_W-1:0]           mh_w_s13;
	logic        [PP_W-1:0]           ml_w_s13;
	logic                             pos_s13;
	logic        [P_W-1:0]            p_sum;
	logic        [MAG_W-1:0]          mag_s14;
	logic                             pos_s14;
	logic                             sat_neg;
	logic                             sat_pos;
	logic        [gwg_pkg::OUT_W-1:0] grad_s15;

	// Displacement of the sample from the centre.
	always_ff @(posedge clk) begin
		d_s1 <= gwg_pkg::D_W'(pos) - gwg_pkg::D_W'(centre);
	end

	// Magnitude, its square, and its product with 1/(2 var).
	assign ad = gwg_pkg::ABS_W'(d_s1[gwg_pkg::D_W-1] ? -d_s1 : d_s1);

	always_ff @(posedge clk) begin
		sq_s2  <= gwg_pkg::SQ_W'(ad) * gwg_pkg::SQ_W'(ad);
		m_s2   <= gwg_pkg::M_W'(ad) * gwg_pkg::M_W'(inv_two_var);
		pos_s2 <= !d_s1[gwg_pkg::D_W-1] && (d_s1 != '0);
	end

	assign sq = sq_s2;

	// Hold the scaled magnitude until the weight of the same transaction arrives.
	always_ff @(posedge clk) begin
		m_line_q[0]   <= m_s2;
		pos_line_q[0] <= pos_s2;
		for (int i = 1; i < gwg_pkg::WEIGHT_LAT; i++) begin
			m_line_q[i]   <= m_line_q[i-1];
			pos_line_q[i] <= pos_line_q[i-1];
		end
	end

	assign m_tap = m_line_q[gwg_pkg::WEIGHT_LAT-1];

	// Product of the scaled magnitude and the weight, in two halves.
	always_ff @(posedge clk) begin
		mh_w_s13 <= PP_W'(m_tap[gwg_pkg::M_W-1:HALF_W]) * PP_W'(weight);
		ml_w_s13 <= PP_W'(m_tap[HALF_W-1:0]) * PP_W'(weight);
		pos_s13  <= pos_line_q[gwg_pkg::WEIGHT_LAT-1];
	end

	// Recombine the halves and drop the fraction bits.
	assign p_sum = {mh_w_s13, {HALF_W{1'b0}}} + P_W'(ml_w_s13);

	always_ff @(posedge clk) begin
		mag_s14 <= p_sum[P_W-1:POS_FRAC_BITS+15];
		pos_s14 <= pos_s13;
	end

	// Saturate and apply the sign, which is opposite to the displacement.
	assign sat_neg = (|mag_s14[MAG_W-1:32]) || (mag_s14[31] && (|mag_s14[30:0]));
	assign sat_pos = |mag_s14[MAG_W-1:31];

	always_ff @(posedge clk) begin
		if (pos_s14) begin
			grad_s15 <= sat_neg ? 32'h8000_0000 : (32'd0 - mag_s14[31:0]);
		end else begin
			grad_s15 <= sat_pos ? 32'h7FFF_FFFF : mag_s14[31:0];
		end
	end

	assign grad = grad_s15;

endmodule

// File: design/gwg_weight.sv
module gwg_weight #(
	parameter int POS_FRAC_BITS   = 16,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                         clk,
	input  logic [gwg_pkg::SQ_W-1:0]     sq_x,
	input  logic [gwg_pkg::SQ_W-1:0]     sq_y,
	input  logic [gwg_pkg::SQ_W-1:0]     sq_z,
	input  logic [gwg_pkg::ITV_W-1:0]    inv_two_var,
	input  logic [gwg_pkg::NORM_W-1:0]   norm_factor,
	output logic [gwg_pkg::OUT_W-1:0]    weight
);

	localparam int S_W    = gwg_pkg::SQ_W + 2;
	localparam int SH_W   = S_W - 24;
	localparam int PHI_W  = SH_W + gwg_pkg::ITV_W;
	localparam int PLO_W  = 24 + gwg_pkg::ITV_W;
	localparam int TWO_F  = 2 * POS_FRAC_BITS;
	localparam int XS_W   = PHI_W + 1;
	localparam int XF_W   = (TWO_F >= 24) ? XS_W : XS_W + 24 - TWO_F;
	localparam int X_W    = 21;
	localparam int YP_W   = X_W + 31;
	localparam int Y_W    = YP_W - 30;
	localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int T_W    = 16 + IDX_W;
	localparam int DP_W   = gwg_pkg::TAB_W + 16;
	localparam int WP_W   = gwg_pkg::NORM_W + gwg_pkg::TAB_W;

	typedef logic [gwg_pkg::TAB_W-1:0] exp_tab_t [EXP_TABLE_DEPTH+1];

	// Table of 2^(-k/depth) in Q.30: Taylor series of exp(-k ln2 / depth), kept non-increasing.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t                    tab;
		logic [63:0]                 z;
		logic [63:0]                 term;
		logic signed [63:0]          sum;
		logic [gwg_pkg::TAB_W-1:0]   val;
		for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
			z = (64'(k) * 64'(gwg_pkg::LN2_Q30) + 64'(EXP_TABLE_DEPTH / 2)) / EXP_TABLE_DEPTH;
			term = 64'd1 << 30;
			sum  = 64'sd1 << 30;
			term = ((term * z) >> 30) / 64'd1;  sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd2;  sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd3;  sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd4;  sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd5;  sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd6;  sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd7;  sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd8;  sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd9;  sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd10; sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd11; sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd12; sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd13; sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd14; sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd15; sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd16; sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd17; sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd18; sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd19; sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd20; sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd21; sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd22; sum = sum + $signed(term);
			term = ((term * z) >> 30) / 64'd23; sum = sum - $signed(term);
			term = ((term * z) >> 30) / 64'd24; sum = sum + $signed(term);
			if (sum < 0) begin
				sum = '0;
			end
			val = sum[gwg_pkg::TAB_W-1:0];
			if (k > 0) begin
				if (val > tab[k-1]) begin
					val = tab[k-1];
				end
			end
			tab[k] = val;
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	logic [S_W-1:0]                 s_s3;
	logic [PHI_W-1:0]               phi_s4;
	logic [PLO_W-1:0]               plo_s4;
	logic [XF_W-1:0]                x_full;
	logic [X_W-1:0]                 x_s5;
	logic                           far_s5;
	logic [YP_W-1:0]                y_prod;
	logic [Y_W-1:0]                 y_s6;
	logic                           far_s6;
	logic [T_W-1:0]                 t_idx;
	logic [IDX_W-1:0]               k_s7;
	logic [15:0]                    r_s7;
	logic [5:0]                     n_s7;
	logic                           far_s7;
	logic [gwg_pkg::TAB_W-1:0]      t0_s8;
	logic [gwg_pkg::TAB_W-1:0]      t1_s8;
	logic [15:0]                    r_s8;
	logic [5:0]                     n_s8;
	logic                           far_s8;
	logic [DP_W-1:0]                dprod_s9;
	logic [gwg_pkg::TAB_W-1:0]      t0_s9;
	logic [5:0]                     n_s9;
	logic                           far_s9;
	logic [gwg_pkg::TAB_W-1:0]      e_val;
	logic [gwg_pkg::TAB_W-1:0]      g_s10;
	logic                           far_s10;
	logic [WP_W-1:0]                wp_s11;
	logic                           far_s11;
	logic [WP_W-1:0]                w_round;
	logic [gwg_pkg::OUT_W-1:0]      weight_s12;

	// Merge the three lanes: squared distance.
	always_ff @(posedge clk) begin
		s_s3 <= S_W'(sq_x) + S_W'(sq_y) + S_W'(sq_z);
	end

	// Scale by 1/(2 var) as two partial products.
	always_ff @(posedge clk) begin
		phi_s4 <= PHI_W'(s_s3[S_W-1:24]) * PHI_W'(inv_two_var);
		plo_s4 <= PLO_W'(s_s3[23:0]) * PLO_W'(inv_two_var);
	end

	// Exponent argument in Q.16, with the far-away cutoff at 32.0.
	generate
		if (TWO_F >= 24) begin : g_shr
			assign x_full = XF_W'((XS_W'(phi_s4) + XS_W'(plo_s4[PLO_W-1:24])) >> (TWO_F - 24));
		end else begin : g_shl
			assign x_full = (XF_W'(phi_s4) << (24 - TWO_F)) + XF_W'(plo_s4 >> TWO_F);
		end
	endgenerate

	always_ff @(posedge clk) begin
		x_s5   <= x_full[X_W-1:0];
		far_s5 <= |x_full[XF_W-1:X_W];
	end

	// Convert to a power of two: y = x * log2(e).
	assign y_prod = YP_W'(x_s5) * YP_W'(gwg_pkg::LOG2E_Q30);

	always_ff @(posedge clk) begin
		y_s6   <= y_prod[YP_W-1:30];
		far_s6 <= far_s5;
	end

	// Split the fraction into a table index and an interpolation weight.
	assign t_idx = T_W'(y_s6[15:0]) * T_W'(EXP_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		k_s7   <= t_idx[T_W-1:16];
		r_s7   <= t_idx[15:0];
		n_s7   <= y_s6[Y_W-1:16];
		far_s7 <= far_s6;
	end

	// Table lookup of both neighbors, registered read.
	always_ff @(posedge clk) begin
		t0_s8  <= EXP_TAB[k_s7];
		t1_s8  <= EXP_TAB[k_s7 + 1'b1];
		r_s8   <= r_s7;
		n_s8   <= n_s7;
		far_s8 <= far_s7;
	end

	// Interpolation step.
	always_ff @(posedge clk) begin
		dprod_s9 <= DP_W'(t0_s8 - t1_s8) * DP_W'(r_s8);
		t0_s9    <= t0_s8;
		n_s9     <= n_s8;
		far_s9   <= far_s8;
	end

	// Integer part of the exponent becomes a right shift.
	assign e_val = t0_s9 - dprod_s9[DP_W-1:16];

	always_ff @(posedge clk) begin
		g_s10   <= e_val >> n_s9;
		far_s10 <= far_s9;
	end

	// Apply the normalization.
	always_ff @(posedge clk) begin
		wp_s11  <= WP_W'(norm_factor) * WP_W'(g_s10);
		far_s11 <= far_s10;
	end

	// Round from Q.54 to Q.24; far samples give zero.
	assign w_round = wp_s11 + WP_W'(64'd1 << 29);

	always_ff @(posedge clk) begin
		weight_s12 <= far_s11 ? '0 : w_round[61:30];
	end

	assign weight = weight_s12;

endmodule

// File: test/gaussian_weight_and_gradient_3d_unit_test.sv
`timescale 1ns / 1ps

module gaussian_weight_and_gradient_3d_unit_test;

	localparam int POS_FRAC_BITS = 16;
	localparam int EXP_DEPTH     = 256;
	localparam int SERIES_TERMS  = 24;
	localparam int PHASE_ITEMS   = 150;
	localparam int NUM_PHASES    = 7;
	localparam int DRAIN_CYCLES  = 24;

	localparam logic [23:0] POS_MAX = 24'h7FFFFF;
	localparam logic [23:0] POS_MIN = 24'h800000;
	localparam logic [23:0] ITV_MAX = 24'hFFFFFF;
	localparam logic [31:0] NRM_MAX = 32'hFFFFFFFF;

	typedef struct packed {
		logic [23:0] pos_x;
		logic [23:0] pos_y;
		logic [23:0] pos_z;
		logic [23:0] centre_x;
		logic [23:0] centre_y;
		logic [23:0] centre_z;
	} sample_t;

	typedef struct packed {
		logic [31:0] weight;
		logic [31:0] grad_x;
		logic [31:0] grad_y;
		logic [31:0] grad_z;
	} kernel_out_t;

	// One directed transaction: the register setting it runs under, the sample, and,
	// where the answer is obvious, the typed-in result.
	typedef struct packed {
		logic [23:0] itv;
		logic [31:0] norm;
		sample_t     stim;
		bit          known;
		kernel_out_t want;
	} directed_row_t;

	localparam int NUM_ROWS = 20;

	directed_row_t directed_rows [NUM_ROWS] = '{
		// Zero displacement at the reset setting: the weight is the norm factor.
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
			1'b1, '{gwg_pkg::NORM_RESET, 32'h0, 32'h0, 32'h0}},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX},
			1'b1, '{gwg_pkg::NORM_RESET, 32'h0, 32'h0, 32'h0}},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN},
			1'b1, '{gwg_pkg::NORM_RESET, 32'h0, 32'h0, 32'h0}},
		// Largest displacements are far from the centre: everything is zero.
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN},
			1'b1, '0},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX},
			1'b1, '0},
		// Eight voxels at variance one lands exactly on the cutoff.
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{24'h080000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
			1'b1, '0},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{24'h0, 24'hF80000, 24'h0, 24'h0, 24'h0, 24'h0},
			1'b1, '0},
		// Just inside the cutoff and a few ordinary displacements.
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{24'h0, 24'h0, 24'h07FFFF, 24'h0, 24'h0, 24'h0},
			1'b0, '0},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{24'h010000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
			1'b0, '0},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{24'hFF0000, 24'h008000, 24'hFFC000, 24'h0, 24'h0, 24'h0},
			1'b0, '0},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{24'h0, 24'h0, 24'h0, 24'h000001, 24'h0, 24'h0},
			1'b0, '0},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{POS_MAX, 24'h0, 24'h0, 24'h7F0001, 24'h0, 24'h0},
			1'b0, '0},
		'{gwg_pkg::ITV_RESET, gwg_pkg::NORM_RESET,
			'{24'h0, POS_MIN, 24'h0, 24'h0, 24'h820000, 24'h0},
			1'b0, '0},
		// A zero inverse variance flattens the kernel: weight is the norm, no gradient.
		'{24'h0, NRM_MAX, '{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN},
			1'b1, '{NRM_MAX, 32'h0, 32'h0, 32'h0}},
		'{24'h0, NRM_MAX, '{POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX},
			1'b1, '{NRM_MAX, 32'h0, 32'h0, 32'h0}},
		// A very narrow, tall kernel drives the gradient into saturation both ways.
		'{ITV_MAX, NRM_MAX, '{24'h000400, 24'hFFFC00, 24'h0, 24'h0, 24'h0, 24'h0},
			1'b0, '0},
		'{ITV_MAX, NRM_MAX, '{24'h0, 24'h0, 24'h0, 24'h000400, 24'hFFFC00, 24'h000200},
			1'b0, '0},
		'{ITV_MAX, NRM_MAX, '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
			1'b1, '{NRM_MAX, 32'h0, 32'h0, 32'h0}},
		// A zero norm factor gives nothing at all.
		'{ITV_MAX, 32'h0, '{24'h000400, 24'hFFFC00, 24'h0, 24'h0, 24'h0, 24'h0},
			1'b1, '0},
		// Smallest nonzero settings against the widest displacement.
		'{24'h1, 32'h1, '{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN},
			1'b0, '0}
	};

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic signed [gwg_pkg::POS_W-1:0] pos_x    = '0;
	logic signed [gwg_pkg::POS_W-1:0] pos_y    = '0;
	logic signed [gwg_pkg::POS_W-1:0] pos_z    = '0;
	logic signed [gwg_pkg::POS_W-1:0] centre_x = '0;
	logic signed [gwg_pkg::POS_W-1:0] centre_y = '0;
	logic signed [gwg_pkg::POS_W-1:0] centre_z = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [gwg_pkg::OUT_W-1:0]        weight;
	logic signed [gwg_pkg::OUT_W-1:0] grad_x;
	logic signed [gwg_pkg::OUT_W-1:0] grad_y;
	logic signed [gwg_pkg::OUT_W-1:0] grad_z;

	// Shadow of the register file, and the exp(-x) table in Q.30.
	logic [23:0]       cur_inv_two_var = gwg_pkg::ITV_RESET;
	logic [31:0]       cur_norm_factor = gwg_pkg::NORM_RESET;
	longint unsigned   exp_lut [0:EXP_DEPTH];
	kernel_out_t       results_due [$];
	int unsigned       mismatch_count  = 0;
	int unsigned       send_idle_pct   = 0;
	int unsigned       stall_pct       = 0;

	gaussian_weight_and_gradient_3d_unit #(
		.POS_FRAC_BITS(POS_FRAC_BITS),
		.EXP_TABLE_DEPTH(EXP_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.centre_x(centre_x),
		.centre_y(centre_y),
		.centre_z(centre_z),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.weight(weight),
		.grad_x(grad_x),
		.grad_y(grad_y),
		.grad_z(grad_z)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Build 2^(-k/EXP_DEPTH) by an integer Taylor series of exp(-k*ln2/EXP_DEPTH),
	// then force the table to be non-increasing.
	initial begin
		longint unsigned z;
		longint unsigned term;
		longint signed   acc;
		for (int k = 0; k <= EXP_DEPTH; k++) begin
			z = (64'(k) * 64'(gwg_pkg::LN2_Q30) + 64'(EXP_DEPTH / 2)) / 64'(EXP_DEPTH);
			acc = 64'sd1 << 30;
			term = 64'd1 << 30;
			for (int n = 1; n <= SERIES_TERMS; n++) begin
				term = ((term * z) >> 30) / 64'(n);
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			exp_lut[k] = acc;
			if (k > 0 && exp_lut[k] > exp_lut[k-1]) begin
				exp_lut[k] = exp_lut[k-1];
			end
		end
	end

	// Weight and gradient of one sample under the current register setting.
	function automatic kernel_out_t gaussian_kernel(input sample_t s);
		logic [23:0]        pv [3];
		logic [23:0]        cv [3];
		logic signed [24:0] d25;
		longint signed      disp [3];
		longint unsigned    ad, sum_sq, x, y, t, k, r, e, g, w, m, part, mag;
		logic [31:0]        grad [3];
		pv[0] = s.pos_x;
		pv[1] = s.pos_y;
		pv[2] = s.pos_z;
		cv[0] = s.centre_x;
		cv[1] = s.centre_y;
		cv[2] = s.centre_z;
		sum_sq = 0;
		for (int i = 0; i < 3; i++) begin
			d25 = {pv[i][23], pv[i]} - {cv[i][23], cv[i]};
			disp[i] = 64'(d25);
			ad = (disp[i] < 0) ? -disp[i] : disp[i];
			sum_sq += ad * ad;
		end

		// Exponent argument in Q.16, split to keep the products within 64 bits.
		x = ((sum_sq >> 24) * 64'(cur_inv_two_var)
			+ (((sum_sq & 64'hFFFFFF) * 64'(cur_inv_two_var)) >> 24))
			>> (2 * POS_FRAC_BITS - 24);
		if (x >= (64'd32 << 16)) begin
			return '0;
		end

		// exp(-x) = 2^-y: table lookup with interpolation, then a shift.
		y = (x * 64'(gwg_pkg::LOG2E_Q30)) >> 30;
		t = (y & 64'hFFFF) * 64'(EXP_DEPTH);
		k = t >> 16;
		r = t & 64'hFFFF;
		if (k >= 64'(EXP_DEPTH)) begin
			k = 64'(EXP_DEPTH - 1);
		end
		e = exp_lut[k] - (((exp_lut[k] - exp_lut[k+1]) * r) >> 16);
		g = ((y >> 16) > 63) ? 64'd0 : (e >> (y >> 16));
		w = ((64'(cur_norm_factor) * g + (64'd1 << 29)) >> 30) & 64'hFFFF_FFFF;

		// Gradient magnitude per axis, sign opposite to the displacement, saturating.
		for (int i = 0; i < 3; i++) begin
			ad = (disp[i] < 0) ? -disp[i] : disp[i];
			m = ad * 64'(cur_inv_two_var);
			part = m * (w >> 16) + ((m * (w & 64'hFFFF)) >> 16);
			mag = part >> (POS_FRAC_BITS - 1);
			if (disp[i] > 0) begin
				if (mag > 64'h8000_0000) begin
					mag = 64'h8000_0000;
				end
				grad[i] = 32'(64'd0 - mag);
			end else begin
				if (mag > 64'h7FFF_FFFF) begin
					mag = 64'h7FFF_FFFF;
				end
				grad[i] = mag[31:0];
			end
		end
		return '{w[31:0], grad[0], grad[1], grad[2]};
	endfunction

	// A random sample: mostly a centre with a displacement of random scale on each
	// axis, so that many land inside the kernel, and some fully scattered pairs.
	function automatic sample_t random_sample();
		logic [23:0] pv [3];
		logic [23:0] cv [3];
		logic [23:0] delta;
		bit          scatter;
		scatter = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < 3; i++) begin
			cv[i] = 24'($urandom);
			delta = 24'($urandom & ((32'd1 << $urandom_range(0, 24)) - 32'd1));
			if (scatter) begin
				pv[i] = 24'($urandom);
			end else if ($urandom_range(0, 1) == 1) begin
				pv[i] = cv[i] - delta;
			end else begin
				pv[i] = cv[i] + delta;
			end
		end
		return '{pv[0], pv[1], pv[2], cv[0], cv[1], cv[2]};
	endfunction

	// Offer one sample transaction, with a random gap before it, and note its result
	// once the block takes it. Entered and left just after a rising edge.
	task automatic send_sample(input sample_t s, input kernel_out_t want);
		bit taken;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		pos_x <= s.pos_x;
		pos_y <= s.pos_y;
		pos_z <= s.pos_z;
		centre_x <= s.centre_x;
		centre_y <= s.centre_y;
		centre_z <= s.centre_z;
		do begin
			@(negedge clk);
			taken = !sample_stall;
			@(posedge clk);
		end while (!taken);
		results_due.push_back(want);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic reg_write(input gwg_pkg::reg_idx_t idx, input logic [31:0] value);
		bit rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Let the pipeline drain completely, then load a new kernel setting.
	task automatic load_kernel_setting(input logic [23:0] itv, input logic [31:0] norm);
		sample_valid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		reg_write(gwg_pkg::REG_INV_TWO_VAR, {8'h0, itv});
		reg_write(gwg_pkg::REG_NORM_FACTOR, norm);
		cur_inv_two_var = itv;
		cur_norm_factor = norm;
	endtask

	// Result side: random stall at each edge.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Check every result transaction against the oldest expectation. Sampled at the
	// falling edge, so the values are those the block presents at the next rising edge.
	always @(negedge clk) begin
		kernel_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (results_due.size() == 0) begin
				$error("result transaction with nothing expected");
				mismatch_count++;
			end else begin
				want = results_due.pop_front();
				if (weight !== want.weight) begin
					$error("weight mismatch: expected %0d, got %0d", want.weight, weight);
					mismatch_count++;
				end
				if (grad_x !== want.grad_x) begin
					$error("grad_x mismatch: expected %0d, got %0d",
						$signed(want.grad_x), grad_x);
					mismatch_count++;
				end
				if (grad_y !== want.grad_y) begin
					$error("grad_y mismatch: expected %0d, got %0d",
						$signed(want.grad_y), grad_y);
					mismatch_count++;
				end
				if (grad_z !== want.grad_z) begin
					$error("grad_z mismatch: expected %0d, got %0d",
						$signed(want.grad_z), grad_z);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [23:0] itv;
		logic [31:0] norm;
		sample_t     s;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed transactions, back to back, under the setting each row names.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].itv != cur_inv_two_var
					|| directed_rows[i].norm != cur_norm_factor) begin
				load_kernel_setting(directed_rows[i].itv, directed_rows[i].norm);
			end
			if (directed_rows[i].known) begin
				send_sample(directed_rows[i].stim, directed_rows[i].want);
			end else begin
				send_sample(directed_rows[i].stim, gaussian_kernel(directed_rows[i].stim));
			end
		end

		// Random phases, each under its own kernel setting, cycling the idle patterns.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin itv = gwg_pkg::ITV_RESET; norm = gwg_pkg::NORM_RESET; end
				1: begin itv = 24'($urandom); norm = $urandom; end
				2: begin itv = ITV_MAX; norm = NRM_MAX; end
				3: begin itv = 24'h0; norm = $urandom; end
				4: begin itv = 24'h1; norm = NRM_MAX; end
				5: begin itv = 24'($urandom_range(0, 65536)); norm = $urandom; end
				default: begin itv = 24'($urandom); norm = $urandom; end
			endcase
			load_kernel_setting(itv, norm);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ((ph + i / 50) % 4)
					0: begin send_idle_pct = 0; stall_pct = 0; end
					1: begin send_idle_pct = 87; stall_pct = 0; end
					2: begin send_idle_pct = 0; stall_pct = 87; end
					default: begin send_idle_pct = 28; stall_pct = 28; end
				endcase
				s = random_sample();
				send_sample(s, gaussian_kernel(s));
			end
		end

		// Drain and report.
		sample_valid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
